// ----- hdl/kmdb_pkg.sv -----
`default_nettype none
package kmdb_pkg;

	// Matrix size defaults.
	localparam int unsigned ROWS_DEFAULT = 16;
	localparam int unsigned COLS_DEFAULT = 16;

	// Fixed field widths of the stream beats.
	localparam int unsigned ROW_W   = 4;
	localparam int unsigned BITS_W  = 16;
	localparam int unsigned TIME_W  = 16;
	localparam int unsigned S_DATA_W = 40;
	localparam int unsigned M_DATA_W = 40;

	// Configuration port.
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NORMAL_THR  = 3'd0,
		CFG_SPECIAL_THR = 3'd1,
		CFG_SPECIAL_EN  = 3'd2,
		CFG_SPECIAL_ROW = 3'd3,
		CFG_SPECIAL_COL = 3'd4
	} kmdb_cfg_idx_t;

	localparam logic [TIME_W-1:0] NORMAL_THR_RESET  = 16'd5;
	localparam logic [TIME_W-1:0] SPECIAL_THR_RESET = 16'd10;

	// Sequencer states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} kmdb_state_t;

endpackage
`default_nettype wire

// ----- hdl/key_matrix_per_key_debounce.sv -----
`default_nettype none
// Per-key debounce for a scanned key matrix. Each input beat carries one scanned
// row (row number, raw key bits, a wrapping 16-bit millisecond time and an
// end-of-scan mark on s_tlast) and produces exactly one output beat with the
// debounced row, the mask of keys that flipped in this step, and, on the last
// row of a scan, whether any key changed during the whole scan. A key's
// debounced bit flips only once its raw bit has disagreed with it for longer
// than the threshold (normal, or the special threshold at one configurable
// position). The per-key timestamps live in a single-port-read, single-port-
// write memory that is walked one column per cycle, so a new beat is not taken
// until every column of the previous row is done and its result has gone into
// the output register, where it is held while the next row is being accepted.
// After reset the timestamps read as zero through one valid bit per row, so
// there is no clearing pass and the block is ready at once.
// Configuration registers should be written only while the block is idle.
module key_matrix_per_key_debounce #(
	parameter int unsigned ROWS = kmdb_pkg::ROWS_DEFAULT,
	parameter int unsigned COLS = kmdb_pkg::COLS_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Input stream. s_tdata from bit 0 up: row_index[3:0], raw_bits[15:0],
	// now_ms[15:0], zero fill. s_tlast is end_of_scan.
	input  wire logic                              s_tvalid,
	output      logic                              s_tready,
	input  wire logic [kmdb_pkg::S_DATA_W-1:0]     s_tdata,
	input  wire logic                              s_tlast,
	// Output stream. m_tdata from bit 0 up: out_row[3:0], stable_bits[15:0],
	// changed_bits[15:0], scan_changed, zero fill. m_tlast is scan_done.
	output      logic                              m_tvalid,
	input  wire logic                              m_tready,
	output      logic [kmdb_pkg::M_DATA_W-1:0]     m_tdata,
	output      logic                              m_tlast,
	// Configuration write port.
	input  wire logic                              cfg_we,
	input  wire logic [kmdb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [kmdb_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned CW    = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int unsigned CW1   = $clog2(COLS + 1);
	localparam int unsigned RXW   = (RW > kmdb_pkg::ROW_W) ? RW : kmdb_pkg::ROW_W;
	localparam int unsigned MAXC  = (COLS > kmdb_pkg::BITS_W) ? COLS : kmdb_pkg::BITS_W;
	localparam int unsigned AW    = RW + CW;
	localparam int unsigned DEPTH = ROWS << CW;
	localparam int unsigned CMPW  = 7;

	localparam int unsigned TW = kmdb_pkg::TIME_W;
	localparam int unsigned BW = kmdb_pkg::BITS_W;
	localparam int unsigned RWF = kmdb_pkg::ROW_W;

	// Configuration registers.
	logic [TW-1:0]  normal_thr_q;
	logic [TW-1:0]  special_thr_q;
	logic           special_en_q;
	logic [RWF-1:0] special_row_q;
	logic [RWF-1:0] special_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_thr_q  <= kmdb_pkg::NORMAL_THR_RESET;
			special_thr_q <= kmdb_pkg::SPECIAL_THR_RESET;
			special_en_q  <= 1'b0;
			special_row_q <= '0;
			special_col_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kmdb_pkg::CFG_NORMAL_THR:  normal_thr_q  <= cfg_data;
				kmdb_pkg::CFG_SPECIAL_THR: special_thr_q <= cfg_data;
				kmdb_pkg::CFG_SPECIAL_EN:  special_en_q  <= cfg_data[0];
				kmdb_pkg::CFG_SPECIAL_ROW: special_row_q <= cfg_data[RWF-1:0];
				kmdb_pkg::CFG_SPECIAL_COL: special_col_q <= cfg_data[RWF-1:0];
				default: ;
			endcase
		end
	end

	// Unpack the input beat.
	logic [RWF-1:0] in_row;
	logic [BW-1:0]  in_raw;
	logic [TW-1:0]  in_now;

	assign in_row = s_tdata[RWF-1:0];
	assign in_raw = s_tdata[RWF+BW-1:RWF];
	assign in_now = s_tdata[RWF+BW+TW-1:RWF+BW];

	kmdb_pkg::kmdb_state_t state_q;

	// Per-item working registers.
	logic [RWF-1:0]  row_q;
	logic [COLS-1:0] raw_q;
	logic [TW-1:0]   now_q;
	logic            last_q;
	logic            in_range_q;
	logic [COLS-1:0] cooked_q;
	logic [COLS-1:0] changed_q;
	logic [CW1-1:0]  rd_col_q;

	// Debounced rows and per-row valid bits for the timestamp memory.
	logic [COLS-1:0] deb_rows_q [ROWS];
	logic [ROWS-1:0] row_valid_q;
	logic            scan_acc_q;

	// Timestamp read stage.
	logic            vld_s1;
	logic [CW-1:0]   col_s1;
	logic [TW-1:0]   rdata_s1;
	logic [TW-1:0]   ts_mem [DEPTH];

	// Output register.
	logic            m_valid_q;
	logic [RWF-1:0]  out_row_q;
	logic [BW-1:0]   out_stable_q;
	logic [BW-1:0]   out_changed_q;
	logic            out_flag_q;
	logic            out_last_q;

	logic [RXW-1:0]  in_row_ext;
	logic [RW-1:0]   in_row_sel;
	logic            in_row_ok;
	logic [RXW-1:0]  row_ext;
	logic [RW-1:0]   row_sel;
	logic [MAXC-1:0] raw_wide;

	assign in_row_ext = RXW'(in_row);
	assign in_row_sel = in_row_ext[RW-1:0];
	assign in_row_ok  = (CMPW'(in_row) < CMPW'(ROWS));
	assign row_ext    = RXW'(row_q);
	assign row_sel    = row_ext[RW-1:0];
	assign raw_wide   = MAXC'(in_raw);

	// Memory access control.
	logic          mem_re;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [TW-1:0] wdata;
	logic          upd;
	logic [TW-1:0] ts;
	logic [TW-1:0] diff;
	logic [TW-1:0] thr;
	logic          is_special;
	logic          mismatch;
	logic          last_col;

	assign mem_re = (state_q == kmdb_pkg::ST_RUN) && (rd_col_q < CW1'(COLS));
	assign raddr  = {row_sel, rd_col_q[CW-1:0]};
	assign waddr  = {row_sel, col_s1};

	// One column per cycle through the shared subtract-and-compare unit.
	// A row never written since reset reads as zero; every column of it is
	// written back on its first pass, so its valid bit can then be set.
	assign ts         = row_valid_q[row_sel] ? rdata_s1 : '0;
	assign diff       = now_q - ts;
	assign is_special = special_en_q && (row_q == special_row_q) &&
	                    (CMPW'(col_s1) == CMPW'(special_col_q));
	assign thr        = is_special ? special_thr_q : normal_thr_q;
	assign mismatch   = cooked_q[col_s1] != raw_q[col_s1];
	assign upd        = mismatch && (diff > thr);
	assign wdata      = (!mismatch || upd) ? now_q : ts;
	assign last_col   = (col_s1 == CW'(COLS - 1));

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			ts_mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_s1 <= ts_mem[raddr];
		end
	end

	// Finishing step: result goes out once the output register is free.
	logic            out_free;
	logic            any_change;
	logic [MAXC-1:0] cooked_wide;
	logic [MAXC-1:0] changed_wide;

	assign out_free     = !m_valid_q || m_tready;
	assign any_change   = |changed_q;
	assign cooked_wide  = MAXC'(cooked_q);
	assign changed_wide = MAXC'(changed_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kmdb_pkg::ST_IDLE;
			vld_s1      <= 1'b0;
			rd_col_q    <= '0;
			row_valid_q <= '0;
			scan_acc_q  <= 1'b0;
			m_valid_q   <= 1'b0;
			for (int r = 0; r < ROWS; r++) begin
				deb_rows_q[r] <= '0;
			end
		end else begin
			vld_s1 <= mem_re;
			if (mem_re) begin
				rd_col_q <= rd_col_q + CW1'(1);
			end
			// In the finishing step the output register is reloaded instead.
			if (m_valid_q && m_tready && state_q != kmdb_pkg::ST_FIN) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				kmdb_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						rd_col_q <= '0;
						state_q  <= in_row_ok ? kmdb_pkg::ST_RUN : kmdb_pkg::ST_FIN;
					end
				end
				kmdb_pkg::ST_RUN: begin
					if (vld_s1 && last_col) begin
						state_q <= kmdb_pkg::ST_FIN;
					end
				end
				kmdb_pkg::ST_FIN: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						if (last_q) begin
							scan_acc_q <= 1'b0;
						end else if (any_change) begin
							scan_acc_q <= 1'b1;
						end
						if (in_range_q) begin
							deb_rows_q[row_sel]  <= cooked_q;
							row_valid_q[row_sel] <= 1'b1;
						end
						state_q <= kmdb_pkg::ST_IDLE;
					end
				end
				default: state_q <= kmdb_pkg::ST_IDLE;
			endcase
		end
	end

	// Payload registers, no reset needed.
	always_ff @(posedge clk) begin
		if (state_q == kmdb_pkg::ST_IDLE && s_tvalid) begin
			row_q      <= in_row;
			raw_q      <= raw_wide[COLS-1:0];
			now_q      <= in_now;
			last_q     <= s_tlast;
			in_range_q <= in_row_ok;
			cooked_q   <= in_row_ok ? deb_rows_q[in_row_sel] : '0;
			changed_q  <= '0;
		end else if (state_q == kmdb_pkg::ST_RUN && vld_s1 && upd) begin
			cooked_q  <= cooked_q ^ (COLS'(1) << col_s1);
			changed_q <= changed_q | (COLS'(1) << col_s1);
		end
		if (state_q == kmdb_pkg::ST_RUN) begin
			col_s1 <= rd_col_q[CW-1:0];
		end
		if (state_q == kmdb_pkg::ST_FIN && out_free) begin
			out_row_q     <= row_q;
			out_stable_q  <= cooked_wide[BW-1:0];
			out_changed_q <= changed_wide[BW-1:0];
			out_flag_q    <= last_q && (scan_acc_q || any_change);
			out_last_q    <= last_q;
		end
	end

	assign s_tready = (state_q == kmdb_pkg::ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = kmdb_pkg::M_DATA_W'({out_flag_q, out_changed_q, out_stable_q, out_row_q});

endmodule
`default_nettype wire

// ----- bench/tb_key_matrix_per_key_debounce.sv -----
`default_nettype none
// Bench for the per-key matrix debouncer.
//
// Row beats go in on the slave stream and each one must come back as exactly one
// result beat on the master stream. A behavioral model inside this module keeps
// its own copy of the per-key timestamps, the debounced rows and the scan change
// flag. It computes the expected result for every accepted input beat and queues
// it. Every accepted output beat is popped against the oldest queued entry and
// compared field by field.
//
// Stimulus comes in two parts. The first is a short hand-written plan. Some of
// its rows carry results that are obvious from the debounce rule: the state right
// after reset, full-row flips, the wrapping timestamp and the scan flag. The
// other rows are checked only against the model. The second part is a set of
// random phases. Each phase first programs all five registers while the block is
// idle, extremes included. It then runs complete, well-formed scans with bouncing
// raw bits, followed by a few beats of pure noise.
module tb_key_matrix_per_key_debounce;

	localparam int unsigned ROWS = kmdb_pkg::ROWS_DEFAULT;
	localparam int unsigned COLS = kmdb_pkg::COLS_DEFAULT;
	localparam int CLOCK_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_PHASES = 8;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [kmdb_pkg::S_DATA_W-1:0] s_tdata;   // row_index[3:0], raw_bits[15:0], now_ms[15:0],
	                                          // zero fill
	logic s_tlast;                            // end_of_scan
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [kmdb_pkg::M_DATA_W-1:0] m_tdata;   // out_row[3:0], stable_bits[15:0],
	                                          // changed_bits[15:0], scan_changed, zero fill
	logic m_tlast;                            // scan_done
	logic cfg_we;
	logic [kmdb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [kmdb_pkg::CFG_DATA_W-1:0] cfg_data;

	key_matrix_per_key_debounce #(
		.ROWS(ROWS),
		.COLS(COLS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// One result beat, in the order in which the fields are packed.
	typedef struct packed {
		logic [3:0] row;
		logic [15:0] stable;
		logic [15:0] changed;
		logic flag;
		logic done;
	} debounce_result_t;

	typedef enum {STEP_BEAT, STEP_CFG} plan_kind_t;

	// A row of the hand-written plan. It is either a register write or a row beat.
	// A beat may carry a result typed in by hand (has_result).
	typedef struct {
		plan_kind_t kind;
		logic [3:0] row;
		logic [15:0] raw;
		logic [15:0] now;
		logic last;
		bit has_result;
		debounce_result_t result;
		kmdb_pkg::kmdb_cfg_idx_t cfg_idx;
		logic [15:0] cfg_val;
	} plan_row_t;

	// Model state. It is cleared the same way as the block at reset.
	logic [15:0] stamp [ROWS][COLS];
	logic [15:0] debounced [ROWS];
	logic scan_acc;
	logic [15:0] thr_normal;
	logic [15:0] thr_special;
	logic spec_en;
	logic [3:0] spec_row;
	logic [3:0] spec_col;

	debounce_result_t awaited_rows[$];
	plan_row_t plan[$];
	debounce_result_t head;
	int mismatches = 0;
	int cycle_count = 0;

	// Flow control shared between the sender and the receiver processes.
	logic calm;
	int hold_asked;
	int hold_served = 0;
	int hold_left = 0;

	// Stimulus-side picture of the keys. A scan reads these with some bounce
	// added on top.
	logic [15:0] phys [ROWS];
	logic [15:0] clock_ms;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Applies one row beat to the model. The debounce rule runs per key: a key
	// that agrees with its debounced bit refreshes its timestamp. A key that
	// disagrees flips only once its wrapped age exceeds the threshold.
	function automatic debounce_result_t debounce_row(input logic [3:0] row,
			input logic [15:0] raw, input logic [15:0] now, input logic last);
		debounce_result_t res;
		logic [15:0] cooked;
		logic [15:0] limit;
		logic [15:0] age;
		res = '0;
		if (row < ROWS) begin
			cooked = debounced[row];
			for (int col = 0; col < COLS; col++) begin
				if (cooked[col] != raw[col]) begin
					limit = (spec_en && row == spec_row && col == spec_col) ?
						thr_special : thr_normal;
					age = now - stamp[row][col];
					if (age > limit) begin
						stamp[row][col] = now;
						cooked[col] = ~cooked[col];
						res.changed[col] = 1'b1;
					end
				end else begin
					stamp[row][col] = now;
				end
			end
			debounced[row] = cooked;
			res.stable = cooked;
		end
		if (res.changed != 16'h0)
			scan_acc = 1'b1;
		// The scan flag is reported only on the last row, and reporting it
		// clears the accumulator.
		res.flag = last ? scan_acc : 1'b0;
		if (last)
			scan_acc = 1'b0;
		res.row = row;
		res.done = last;
		return res;
	endfunction

	function automatic void add_beat(input logic [3:0] row, input logic [15:0] raw,
			input logic [15:0] now, input logic last);
		plan_row_t p;
		p.kind = STEP_BEAT;
		p.row = row;
		p.raw = raw;
		p.now = now;
		p.last = last;
		p.has_result = 1'b0;
		p.result = '0;
		p.cfg_idx = kmdb_pkg::CFG_NORMAL_THR;
		p.cfg_val = 16'h0;
		plan.push_back(p);
	endfunction

	function automatic void add_typed(input logic [3:0] row, input logic [15:0] raw,
			input logic [15:0] now, input logic last, input logic [15:0] stable,
			input logic [15:0] changed, input logic flag);
		plan_row_t p;
		p.kind = STEP_BEAT;
		p.row = row;
		p.raw = raw;
		p.now = now;
		p.last = last;
		p.has_result = 1'b1;
		p.result = '{row: row, stable: stable, changed: changed, flag: flag, done: last};
		p.cfg_idx = kmdb_pkg::CFG_NORMAL_THR;
		p.cfg_val = 16'h0;
		plan.push_back(p);
	endfunction

	function automatic void add_cfg(input kmdb_pkg::kmdb_cfg_idx_t idx,
			input logic [15:0] val);
		plan_row_t p;
		p.kind = STEP_CFG;
		p.row = 4'h0;
		p.raw = 16'h0;
		p.now = 16'h0;
		p.last = 1'b0;
		p.has_result = 1'b0;
		p.result = '0;
		p.cfg_idx = idx;
		p.cfg_val = val;
		plan.push_back(p);
	endfunction

	// Offers one beat and waits for it to be accepted. The inputs change only at
	// the falling edge. tvalid stays high from one beat to the next unless an
	// idle gap is chosen, so it is never lowered and raised in the same step.
	task automatic send_beat(input logic [3:0] row, input logic [15:0] raw,
			input logic [15:0] now, input logic last, input bit has_result,
			input debounce_result_t typed);
		debounce_result_t res;
		while (!calm && $urandom_range(99) < 7) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, now, raw, row};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		// The model runs even for beats with a hand-typed result, so that its
		// state keeps track of the block.
		res = debounce_row(row, raw, now, last);
		if (has_result)
			res = typed;
		awaited_rows.push_back(res);
		@(negedge clk);
	endtask

	// Stops offering beats, waits for every expected result, then lets the block
	// return to idle with some margin.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (awaited_rows.size() != 0)
			@(negedge clk);
		repeat (COLS + 8) @(negedge clk);
	endtask

	// Writes one register and mirrors the write in the model. It is called
	// only while the block is idle.
	task automatic set_reg(input kmdb_pkg::kmdb_cfg_idx_t idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		case (idx)
			kmdb_pkg::CFG_NORMAL_THR: begin
				thr_normal = val;
			end
			kmdb_pkg::CFG_SPECIAL_THR: begin
				thr_special = val;
			end
			kmdb_pkg::CFG_SPECIAL_EN: begin
				spec_en = val[0];
			end
			kmdb_pkg::CFG_SPECIAL_ROW: begin
				spec_row = val[3:0];
			end
			kmdb_pkg::CFG_SPECIAL_COL: begin
				spec_col = val[3:0];
			end
			default: begin
			end
		endcase
	endtask

	// One random phase. It programs every register, then runs three complete
	// scans of rows 0 to ROWS-1 with time moving forward, keys being pressed or
	// released, and contact bounce. A few beats of noise follow. Thresholds are
	// mostly small so that keys really flip. Some phases pin the extremes.
	task automatic random_phase(input int p);
		logic [15:0] bounce;
		logic [15:0] v_normal;
		logic [15:0] v_special;
		logic [3:0] v_row;
		logic [3:0] v_col;
		debounce_result_t none;
		none = '0;
		v_normal = (p == 1) ? 16'h0000 : (p == 2) ? 16'hFFFF : 16'($urandom_range(30));
		v_special = (p == 3) ? 16'hFFFF : (p == 4) ? 16'h0000 : 16'($urandom_range(60));
		v_row = (p == 3) ? 4'hF : (p == 4) ? 4'h0 : 4'($urandom);
		v_col = (p == 3) ? 4'hF : (p == 4) ? 4'h0 : 4'($urandom);
		settle();
		set_reg(kmdb_pkg::CFG_NORMAL_THR, v_normal);
		set_reg(kmdb_pkg::CFG_SPECIAL_THR, v_special);
		set_reg(kmdb_pkg::CFG_SPECIAL_EN, (p == 0 || p == 6) ? 16'h0 : 16'h1);
		set_reg(kmdb_pkg::CFG_SPECIAL_ROW, {12'h0, v_row});
		set_reg(kmdb_pkg::CFG_SPECIAL_COL, {12'h0, v_col});
		// Phase 5 runs with no idling on either side. Phase 2 asks the receiver
		// for one long hold-off, which backs the block up onto its input.
		calm <= (p == 5);
		if (p == 2)
			hold_asked <= hold_asked + 1;
		for (int s = 0; s < 3; s++) begin
			// An occasional large step in time exercises the upper bits of now_ms
			// and the wrap of the age computation.
			if ($urandom_range(9) == 0)
				clock_ms = clock_ms + 16'($urandom);
			for (int r = 0; r < ROWS; r++) begin
				if ($urandom_range(99) < 5)
					phys[r] = 16'($urandom);
				else if ($urandom_range(99) < 30)
					phys[r] = phys[r] ^ (16'h1 << $urandom_range(COLS - 1));
				if (r == spec_row && $urandom_range(99) < 40)
					phys[r][spec_col] = ~phys[r][spec_col];
				bounce = ($urandom_range(99) < 25) ? (16'h1 << $urandom_range(COLS - 1)) :
					16'h0;
				clock_ms = clock_ms + 16'($urandom_range(3));
				send_beat(4'(r), phys[r] ^ bounce, clock_ms, r == ROWS - 1, 1'b0, none);
			end
		end
		for (int k = 0; k < 6; k++)
			send_beat(4'($urandom), 16'($urandom), 16'($urandom), 1'($urandom), 1'b0, none);
	endtask

	// Compares one field. On a mismatch it reports the field and counts the
	// error, and the run goes on.
	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endtask

	// Result monitor. It samples at the rising edge, where a beat moves when
	// both tvalid and tready are high.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_rows.size() == 0) begin
				$error("result beat with no expected result: tdata %h tlast %b",
					m_tdata, m_tlast);
				mismatches++;
			end else begin
				head = awaited_rows.pop_front();
				check_field("out_row", {12'h0, head.row}, {12'h0, m_tdata[3:0]});
				check_field("stable_bits", head.stable, m_tdata[19:4]);
				check_field("changed_bits", head.changed, m_tdata[35:20]);
				check_field("scan_changed", {15'h0, head.flag}, {15'h0, m_tdata[36]});
				check_field("scan_done", {15'h0, head.done}, {15'h0, m_tlast});
				check_field("zero fill", 16'h0,
					{13'h0, m_tdata[kmdb_pkg::M_DATA_W-1:37]});
			end
		end
	end

	// Receiver. It stalls at random, except in calm stretches. When asked, it
	// holds tready low until hold_left, loaded from HOLD_CYCLES, has counted down
	// to zero, while the sender keeps offering beats.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_served != hold_asked) begin
			hold_served <= hold_asked;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 7);
		end
	end

	// Watchdog. It ends a run that hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CLOCK_LIMIT) begin
			$display("** key_matrix_per_key_debounce: FAILED **");
			$finish;
		end
	end

	initial begin
		debounce_result_t none;
		none = '0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		hold_asked = 0;
		clock_ms = 16'h0;
		thr_normal = kmdb_pkg::NORMAL_THR_RESET;
		thr_special = kmdb_pkg::SPECIAL_THR_RESET;
		spec_en = 1'b0;
		spec_row = 4'h0;
		spec_col = 4'h0;
		scan_acc = 1'b0;
		for (int r = 0; r < ROWS; r++) begin
			debounced[r] = 16'h0;
			phys[r] = 16'h0;
			for (int c = 0; c < COLS; c++)
				stamp[r][c] = 16'h0;
		end

		// Reset defaults: normal wait 5, special wait 10, special key off.
		// From reset, a key whose raw bit agrees keeps its stamp fresh.
		add_typed(4'd0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0);
		// An age of exactly the threshold does not flip.
		add_typed(4'd0, 16'hFFFF, 16'h0005, 1'b0, 16'h0000, 16'h0000, 1'b0);
		// One more millisecond flips the whole row, and the last row reports it.
		add_typed(4'd0, 16'hFFFF, 16'h0006, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
		// Top row and top column at the top of the time range.
		add_typed(4'd15, 16'h8000, 16'hFFFF, 1'b0, 16'h8000, 16'h8000, 1'b0);
		// The time wraps: an age of 4 is too young, but the change from the
		// earlier row of this scan still sets the scan flag.
		add_typed(4'd15, 16'h0000, 16'h0003, 1'b1, 16'h8000, 16'h0000, 1'b1);
		add_typed(4'd15, 16'h0000, 16'h0005, 1'b1, 16'h0000, 16'h8000, 1'b1);
		// A last row with no change in its scan reports no change.
		add_typed(4'd7, 16'h0000, 16'h1234, 1'b1, 16'h0000, 16'h0000, 1'b0);
		add_beat(4'd0, 16'h0000, 16'h0010, 1'b0);
		add_beat(4'd9, 16'hA5A5, 16'h8000, 1'b1);
		// Special key at row 2, column 7 with the longest wait. Ordinary keys get
		// a zero wait, so they flip on any later millisecond but not within the
		// same one.
		add_cfg(kmdb_pkg::CFG_NORMAL_THR, 16'h0000);
		add_cfg(kmdb_pkg::CFG_SPECIAL_THR, 16'hFFFF);
		add_cfg(kmdb_pkg::CFG_SPECIAL_EN, 16'h0001);
		add_cfg(kmdb_pkg::CFG_SPECIAL_ROW, 16'h0002);
		add_cfg(kmdb_pkg::CFG_SPECIAL_COL, 16'h0007);
		add_beat(4'd2, 16'h0080, 16'h2000, 1'b0);
		add_beat(4'd2, 16'h00FF, 16'h2001, 1'b0);
		add_beat(4'd2, 16'h0000, 16'h2001, 1'b1);
		add_beat(4'd2, 16'h0000, 16'h2002, 1'b0);
		// The opposite extremes, at the top corner of the matrix.
		add_cfg(kmdb_pkg::CFG_NORMAL_THR, 16'hFFFF);
		add_cfg(kmdb_pkg::CFG_SPECIAL_THR, 16'h0000);
		add_cfg(kmdb_pkg::CFG_SPECIAL_ROW, 16'h000F);
		add_cfg(kmdb_pkg::CFG_SPECIAL_COL, 16'h000F);
		add_beat(4'd15, 16'hFFFF, 16'h4000, 1'b0);
		add_beat(4'd15, 16'hFFFF, 16'h3FFF, 1'b1);
		// With the special key turned off, the corner key falls back to the
		// normal wait.
		add_cfg(kmdb_pkg::CFG_SPECIAL_EN, 16'h0000);
		add_cfg(kmdb_pkg::CFG_NORMAL_THR, 16'h0003);
		add_beat(4'd15, 16'h0000, 16'h4003, 1'b0);
		add_beat(4'd15, 16'h0000, 16'h4004, 1'b1);

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_CFG) begin
				settle();
				set_reg(plan[i].cfg_idx, plan[i].cfg_val);
			end else begin
				send_beat(plan[i].row, plan[i].raw, plan[i].now, plan[i].last,
					plan[i].has_result, plan[i].has_result ? plan[i].result : none);
			end
		end

		clock_ms = 16'h4100;
		for (int p = 0; p < RANDOM_PHASES; p++)
			random_phase(p);

		settle();
		if (mismatches == 0) begin
			$display("** key_matrix_per_key_debounce: PASSED **");
		end else begin
			$display("** key_matrix_per_key_debounce: FAILED **");
		end
		$finish;
	end

endmodule
`default_nettype wire
